// ===== src/itch_message_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// itch_message_decoder_macros.svh
// Assertion macros used by the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef ITCH_MESSAGE_DECODER_MACROS_SVH
`define ITCH_MESSAGE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define IMD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("itch decoder check failed");

// Next-cycle implication, disabled while in reset.
`define IMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("itch decoder check failed");

`endif

// ===== src/imd_pkg.sv =====
// ----------------------------------------------------------------------------
// imd_pkg
// Types and codes shared by the market-data message decoder.
// ----------------------------------------------------------------------------
package imd_pkg;

    localparam int CAPTURE_BYTES = 48;
    localparam int CAP_IDX_W     = $clog2(CAPTURE_BYTES);

    // record kinds
    localparam logic [3:0] KIND_SYSEVENT   = 4'd0;
    localparam logic [3:0] KIND_DIRECTORY  = 4'd1;
    localparam logic [3:0] KIND_ADD        = 4'd2;
    localparam logic [3:0] KIND_EXEC       = 4'd3;
    localparam logic [3:0] KIND_EXEC_PRICE = 4'd4;
    localparam logic [3:0] KIND_CANCEL     = 4'd5;
    localparam logic [3:0] KIND_DELETE     = 4'd6;
    localparam logic [3:0] KIND_REPLACE    = 4'd7;
    localparam logic [3:0] KIND_TRADE      = 4'd8;
    localparam logic [3:0] KIND_CROSS      = 4'd9;
    localparam logic [3:0] KIND_IGNORED    = 4'd10;
    localparam logic [3:0] KIND_UNKNOWN    = 4'd11;

    typedef logic [CAPTURE_BYTES-1:0][7:0] t_capture;

    typedef struct packed {
        logic [3:0]  msg_kind;
        logic [15:0] locate_code;
        logic [15:0] track_seq;
        logic [47:0] stamp_ns;
        logic [63:0] order_ref;
        logic [63:0] new_order_ref;
        logic [7:0]  side;
        logic [63:0] shares;
        logic [31:0] price;
        logic [63:0] match_id;
        logic [63:0] stock_symbol;
        logic [7:0]  attribute_byte;
    } t_record;

endpackage

// ===== src/imd_if.sv =====
// ----------------------------------------------------------------------------
// imd_if
// Valid/ready channels: stream bytes in, decoded records out.
// ----------------------------------------------------------------------------
interface imd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface imd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  msg_kind;
    logic [15:0] locate_code;
    logic [15:0] track_seq;
    logic [47:0] stamp_ns;
    logic [63:0] order_ref;
    logic [63:0] new_order_ref;
    logic [7:0]  side;
    logic [63:0] shares;
    logic [31:0] price;
    logic [63:0] match_id;
    logic [63:0] stock_symbol;
    logic [7:0]  attribute_byte;

    modport source (output valid, output msg_kind, output locate_code,
                    output track_seq, output stamp_ns, output order_ref,
                    output new_order_ref, output side, output shares, output price,
                    output match_id, output stock_symbol, output attribute_byte,
                    input ready);
    modport sink   (input valid, input msg_kind, input locate_code,
                    input track_seq, input stamp_ns, input order_ref,
                    input new_order_ref, input side, input shares, input price,
                    input match_id, input stock_symbol, input attribute_byte,
                    output ready);
endinterface

// ===== src/imd_decode.sv =====
// ----------------------------------------------------------------------------
// imd_decode
// Field decode of a captured message body into the record register.
// ----------------------------------------------------------------------------
module imd_decode
    import imd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_pend,      // capture holds a finished message
    input  t_capture  i_cap,
    output logic      o_take,      // record register takes it this cycle
    imd_out_if.source o_out
);

    localparam logic [7:0] TYPE_S  = 8'h53;
    localparam logic [7:0] TYPE_R  = 8'h52;
    localparam logic [7:0] TYPE_A  = 8'h41;
    localparam logic [7:0] TYPE_F  = 8'h46;
    localparam logic [7:0] TYPE_E  = 8'h45;
    localparam logic [7:0] TYPE_C  = 8'h43;
    localparam logic [7:0] TYPE_X  = 8'h58;
    localparam logic [7:0] TYPE_D  = 8'h44;
    localparam logic [7:0] TYPE_U  = 8'h55;
    localparam logic [7:0] TYPE_P  = 8'h50;
    localparam logic [7:0] TYPE_Q  = 8'h51;
    localparam logic [7:0] TYPE_H  = 8'h48;
    localparam logic [7:0] TYPE_Y  = 8'h59;
    localparam logic [7:0] TYPE_L  = 8'h4C;
    localparam logic [7:0] TYPE_V  = 8'h56;
    localparam logic [7:0] TYPE_W  = 8'h57;
    localparam logic [7:0] TYPE_K  = 8'h4B;
    localparam logic [7:0] TYPE_J  = 8'h4A;
    localparam logic [7:0] TYPE_LH = 8'h68;
    localparam logic [7:0] TYPE_B  = 8'h42;
    localparam logic [7:0] TYPE_I  = 8'h49;
    localparam logic [7:0] TYPE_N  = 8'h4E;
    localparam logic [7:0] TYPE_O  = 8'h4F;

    // bytes beyond the capture read as zero
    function automatic logic [7:0] cap_at(input t_capture c, input int idx);
        logic [7:0] v;
        v = 8'h00;
        if (idx < CAPTURE_BYTES) begin
            v = c[idx];
        end
        return v;
    endfunction

    // big-endian field of up to eight bytes
    function automatic logic [63:0] be_field(input t_capture c, input int pos,
                                             input int n);
        logic [63:0] v;
        v = 64'h0;
        for (int k = 0; k < n; k++) begin
            v = {v[55:0], cap_at(c, pos + k)};
        end
        return v;
    endfunction

    function automatic t_record decode(input t_capture c);
        t_record    r;
        logic [7:0] t;
        logic [63:0] f4a, f4b, f4c;
        t   = cap_at(c, 0);
        r   = '0;
        f4a = be_field(c, 20, 4);
        f4b = be_field(c, 19, 4);
        f4c = be_field(c, 32, 4);
        r.locate_code = {cap_at(c, 1), cap_at(c, 2)};
        r.track_seq   = {cap_at(c, 3), cap_at(c, 4)};
        r.stamp_ns    = {cap_at(c, 5), cap_at(c, 6), cap_at(c, 7),
                         cap_at(c, 8), cap_at(c, 9), cap_at(c, 10)};
        unique case (t) inside
            TYPE_S: begin
                r.msg_kind       = KIND_SYSEVENT;
                r.attribute_byte = cap_at(c, 11);
            end
            TYPE_R: begin
                r.msg_kind     = KIND_DIRECTORY;
                r.stock_symbol = be_field(c, 11, 8);
            end
            TYPE_A, TYPE_F, TYPE_P: begin
                r.msg_kind     = (t == TYPE_P) ? KIND_TRADE : KIND_ADD;
                r.order_ref    = be_field(c, 11, 8);
                r.side         = cap_at(c, 19);
                r.shares       = f4a;
                r.stock_symbol = be_field(c, 24, 8);
                r.price        = f4c[31:0];
                if (t == TYPE_P) begin
                    r.match_id = be_field(c, 36, 8);
                end
            end
            TYPE_E, TYPE_C: begin
                r.msg_kind  = (t == TYPE_C) ? KIND_EXEC_PRICE : KIND_EXEC;
                r.order_ref = be_field(c, 11, 8);
                r.shares    = f4b;
                r.match_id  = be_field(c, 23, 8);
                if (t == TYPE_C) begin
                    r.attribute_byte = cap_at(c, 31);
                    r.price          = f4c[31:0];
                end
            end
            TYPE_X: begin
                r.msg_kind  = KIND_CANCEL;
                r.order_ref = be_field(c, 11, 8);
                r.shares    = f4b;
            end
            TYPE_D: begin
                r.msg_kind  = KIND_DELETE;
                r.order_ref = be_field(c, 11, 8);
            end
            TYPE_U: begin
                r.msg_kind      = KIND_REPLACE;
                r.order_ref     = be_field(c, 11, 8);
                r.new_order_ref = be_field(c, 19, 8);
                r.shares        = be_field(c, 27, 4);
                r.price         = {cap_at(c, 31), cap_at(c, 32), cap_at(c, 33),
                                   cap_at(c, 34)};
            end
            TYPE_Q: begin
                r.msg_kind       = KIND_CROSS;
                r.shares         = be_field(c, 11, 8);
                r.stock_symbol   = be_field(c, 19, 8);
                r.price          = {cap_at(c, 27), cap_at(c, 28), cap_at(c, 29),
                                    cap_at(c, 30)};
                r.match_id       = be_field(c, 31, 8);
                r.attribute_byte = cap_at(c, 39);
            end
            TYPE_H, TYPE_Y, TYPE_L, TYPE_V, TYPE_W, TYPE_K,
            TYPE_J, TYPE_LH, TYPE_B, TYPE_I, TYPE_N, TYPE_O: begin
                r.msg_kind = KIND_IGNORED;
            end
            default: begin
                r.msg_kind       = KIND_UNKNOWN;
                r.attribute_byte = t;
            end
        endcase
        return r;
    endfunction

    t_record r_rec;
    logic    r_valid;
    logic    n_valid;

    assign o_take = i_pend && (!r_valid || o_out.ready);

    always_comb begin
        n_valid = r_valid;
        if (o_take) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_rec <= decode(i_cap);
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.msg_kind       = r_rec.msg_kind;
    assign o_out.locate_code    = r_rec.locate_code;
    assign o_out.track_seq      = r_rec.track_seq;
    assign o_out.stamp_ns       = r_rec.stamp_ns;
    assign o_out.order_ref      = r_rec.order_ref;
    assign o_out.new_order_ref  = r_rec.new_order_ref;
    assign o_out.side           = r_rec.side;
    assign o_out.shares         = r_rec.shares;
    assign o_out.price          = r_rec.price;
    assign o_out.match_id       = r_rec.match_id;
    assign o_out.stock_symbol   = r_rec.stock_symbol;
    assign o_out.attribute_byte = r_rec.attribute_byte;

endmodule

// ===== src/itch_message_decoder.sv =====
// ----------------------------------------------------------------------------
// itch_message_decoder
// Frames a length-prefixed market-data byte stream and decodes one record
// per message.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                              One transfer is
//  -------  ---  -----------------------------------  ----------------------
//  i_in     in   data_byte, buffer_end                one stream byte
//  o_out    out  msg_kind ... attribute_byte          one decoded record
//
//  One byte per cycle while the input is not stalled. The record of a message
//  is registered in the record register after the capture holds its last body
//  byte (decode sits between the capture registers and the record register).
//  Reset (i_rst_n low, synchronous) returns framing to the length high byte
//  and empties the record register; no clearing pass.
//  Input stalls only when a decoded message waits for the record register
//  and the record register is held by o_out.ready low.
//
module itch_message_decoder
    import imd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    imd_in_if.sink    i_in,
    imd_out_if.source o_out
);

    // framing phases
    localparam logic [1:0] PH_LEN_HI = 2'd0;
    localparam logic [1:0] PH_LEN_LO = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_len,   n_len;
    logic [15:0] r_pos,   n_pos;
    logic        r_pend,  n_pend;
    t_capture    r_cap;

    logic        accept;
    logic        take;
    logic        done;      // last body byte taken this cycle
    logic        clear_cap; // fresh message body starts
    logic        write_cap;
    logic [15:0] pos_inc;
    logic [15:0] full_len;

    // A finished message stays in the capture until the decoder takes it.
    assign i_in.ready = !r_pend || take;
    assign accept     = i_in.valid && i_in.ready;

    assign pos_inc  = r_pos + 16'd1;
    assign full_len = {r_len[15:8], i_in.data_byte};

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_pos     = r_pos;
        done      = 1'b0;
        clear_cap = 1'b0;
        write_cap = 1'b0;
        if (accept) begin
            unique case (r_phase)
                PH_LEN_HI: begin
                    n_len   = {i_in.data_byte, 8'h00};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len = full_len;
                    n_pos = 16'd0;
                    if (full_len == 16'd0) begin
                        n_phase = PH_SKIP;   // empty message: skip one byte
                    end else begin
                        clear_cap = 1'b1;
                        n_phase   = PH_BODY;
                    end
                end
                PH_BODY: begin
                    // bytes past the capture are counted, not stored
                    write_cap = (r_pos < 16'(CAPTURE_BYTES));
                    n_pos     = pos_inc;
                    if (pos_inc >= r_len) begin
                        done    = 1'b1;
                        n_phase = PH_LEN_HI;
                    end
                end
                default: begin
                    n_phase = PH_LEN_HI;
                end
            endcase
            // buffer end drops any unfinished message
            if (i_in.buffer_end) begin
                n_phase = PH_LEN_HI;
            end
        end
    end

    always_comb begin
        n_pend = r_pend;
        if (done) begin
            n_pend = 1'b1;
        end else if (take) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN_HI;
            r_len   <= 16'd0;
            r_pos   <= 16'd0;
            r_pend  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_pend  <= n_pend;
        end
    end

    // Capture cleared at body start so short messages read zero beyond
    // their length.
    always_ff @(posedge i_clk) begin
        if (clear_cap) begin
            r_cap <= '0;
        end else if (write_cap) begin
            r_cap[r_pos[CAP_IDX_W-1:0]] <= i_in.data_byte;
        end
    end

    imd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pend  (r_pend),
        .i_cap   (r_cap),
        .o_take  (take),
        .o_out   (o_out)
    );

endmodule

// ===== src/imd_checker.sv =====
// ----------------------------------------------------------------------------
// imd_checker
// Port-level checks on the decoder's record stream.
// ----------------------------------------------------------------------------
`include "itch_message_decoder_macros.svh"

module imd_checker
    import imd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_msg_kind,
    input logic [63:0] i_new_order_ref,
    input logic [7:0]  i_attribute_byte,
    input logic [7:0]  i_side
);

    // stalled record holds its kind
    `IMD_ASSERT_NEXT(a_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_msg_kind))

    // kind stays within the defined codes
    `IMD_ASSERT_NOW(a_kind, i_out_valid, i_msg_kind <= KIND_UNKNOWN)

    // only replace carries a new reference
    `IMD_ASSERT_NOW(a_newref, i_out_valid && i_msg_kind != KIND_REPLACE, i_new_order_ref == 64'h0)

    // attribute byte only for system event, exec with price, cross, unknown; side only for add and trade
    `IMD_ASSERT_NOW(a_attr, i_out_valid && i_msg_kind != KIND_SYSEVENT && i_msg_kind != KIND_EXEC_PRICE && i_msg_kind != KIND_CROSS && i_msg_kind != KIND_UNKNOWN, i_attribute_byte == 8'h00 && (i_side == 8'h00 || i_msg_kind == KIND_ADD || i_msg_kind == KIND_TRADE))

endmodule

bind itch_message_decoder imd_checker u_imd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_msg_kind       (o_out.msg_kind),
    .i_new_order_ref  (o_out.new_order_ref),
    .i_attribute_byte (o_out.attribute_byte),
    .i_side           (o_out.side)
);
